/* sv/cqf_pkg.sv */
package cqf_pkg;

    // Default sizes of the slot store.
    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed widths of the transaction fields.
    localparam int FIELD_W  = 32;
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 4;

    // Configuration port.
    localparam int                PDATA_W        = 32;
    localparam int                ADDR_W         = 3;
    localparam int                CFG_W          = 5;
    localparam logic [CFG_W-1:0]  RING_SLOTS_RST = 5'd10;
    localparam logic [ADDR_W-3:0] REG_RING_SLOTS = 1'b0;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_STATUS = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_POP    = 2'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd3;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_READ = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic exec;
        logic read;
        logic load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

/* sv/cqf_regs.sv */
module cqf_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cqf_pkg::ADDR_W-1:0]      paddr,
    input  logic [cqf_pkg::PDATA_W-1:0]     pwdata,
    output logic [cqf_pkg::PDATA_W-1:0]     prdata,
    output logic                            pready,
    output logic [cqf_pkg::CFG_W-1:0]       o_ring_slots,
    output logic                            o_cfg_wr
);

    logic [cqf_pkg::CFG_W-1:0] r_ring_slots;
    logic                      reg_hit;

    // Only one register is decoded; other word addresses are ignored.
    assign reg_hit  = (paddr[cqf_pkg::ADDR_W-1:2] == cqf_pkg::REG_RING_SLOTS);
    assign pready   = 1'b1;
    assign o_cfg_wr = psel && penable && pwrite && reg_hit;

    // The ring size register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_slots <= cqf_pkg::RING_SLOTS_RST;
        end else if (o_cfg_wr) begin
            r_ring_slots <= pwdata[cqf_pkg::CFG_W-1:0];
        end
    end

    // Read back.
    assign prdata       = reg_hit ? cqf_pkg::PDATA_W'(r_ring_slots) : '0;
    assign o_ring_slots = r_ring_slots;

endmodule

/* sv/cqf_ctrl.sv */
module cqf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  cqf_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output cqf_pkg::t_cmd o_cmd
);

    cqf_pkg::t_state r_state;
    cqf_pkg::t_state n_state;

    assign o_in_ready = (r_state == cqf_pkg::S_IDLE);

    // Next state and command decode.
    always_comb begin
        n_state       = r_state;
        o_cmd.capture = 1'b0;
        o_cmd.exec    = 1'b0;
        o_cmd.read    = 1'b0;
        o_cmd.load    = 1'b0;
        unique case (r_state)
            cqf_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = cqf_pkg::S_EXEC;
                end
            end
            cqf_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = cqf_pkg::S_READ;
            end
            cqf_pkg::S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = cqf_pkg::S_DONE;
            end
            cqf_pkg::S_DONE: begin
                // Hold the finished result until the output register frees up.
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = cqf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cqf_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cqf_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* sv/cqf_dp.sv */
module cqf_dp #(
    parameter int DEPTH      = cqf_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = cqf_pkg::DATA_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  cqf_pkg::t_cmd                       i_cmd,
    output cqf_pkg::t_sts                       o_sts,
    input  logic                                i_cfg_wr,
    input  logic [cqf_pkg::CFG_W-1:0]           i_ring_slots,
    input  logic [cqf_pkg::REQ_W-1:0]           i_req_type,
    input  logic [cqf_pkg::FIELD_W-1:0]         i_data_in,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [cqf_pkg::STATUS_W-1:0]        o_status,
    output logic [cqf_pkg::FIELD_W-1:0]         o_head_value,
    output logic [cqf_pkg::FIELD_W-1:0]         o_tail_value,
    output logic [cqf_pkg::OCC_W-1:0]           o_occupancy,
    output logic                                o_is_empty,
    output logic                                o_is_full
);

    localparam int PW = $clog2(DEPTH);
    localparam int NW = PW + 1;
    localparam int CW = (NW > cqf_pkg::CFG_W) ? NW : cqf_pkg::CFG_W;
    localparam int XW = (DATA_WIDTH > cqf_pkg::FIELD_W) ? DATA_WIDTH : cqf_pkg::FIELD_W;

    // Slot store and pointers.
    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]         r_rd_ptr;
    logic [PW-1:0]         r_wr_ptr;

    // Captured transaction.
    logic [cqf_pkg::REQ_W-1:0]   r_req;
    logic [cqf_pkg::FIELD_W-1:0] r_data;

    // Intermediate result.
    logic [cqf_pkg::STATUS_W-1:0] r_status;
    logic [DATA_WIDTH-1:0]        r_rd_head;
    logic [DATA_WIDTH-1:0]        r_rd_tail;
    logic [NW-1:0]                r_occ;
    logic                         r_empty;
    logic                         r_full;
    logic                         r_out_valid;

    logic [CW-1:0]                slots_c;
    logic [NW-1:0]                n_slots;
    logic [PW-1:0]                wr_adv;
    logic [PW-1:0]                rd_adv;
    logic [PW-1:0]                last_ptr;
    logic [NW-1:0]                occ;
    logic [PW-1:0]                n_rd_ptr;
    logic [PW-1:0]                n_wr_ptr;
    logic [cqf_pkg::STATUS_W-1:0] n_status;
    logic                         mem_we;

    // Advance a pointer by one slot, wrapping at the ring size.
    function automatic logic [PW-1:0] adv(input logic [PW-1:0] p, input logic [NW-1:0] nn);
        logic [NW-1:0] q;
        q = NW'(p) + NW'(1);
        return (q == nn) ? '0 : q[PW-1:0];
    endfunction

    // Ring size in use, clamped to the legal range.
    always_comb begin
        slots_c = CW'(i_ring_slots);
        if (slots_c < CW'(2)) begin
            slots_c = CW'(2);
        end else if (slots_c > CW'(DEPTH)) begin
            slots_c = CW'(DEPTH);
        end
        n_slots = NW'(slots_c);
    end

    assign wr_adv   = adv(r_wr_ptr, n_slots);
    assign rd_adv   = adv(r_rd_ptr, n_slots);
    assign last_ptr = (r_wr_ptr == '0) ? PW'(n_slots - NW'(1)) : (r_wr_ptr - PW'(1));
    assign occ      = (r_wr_ptr >= r_rd_ptr) ? (NW'(r_wr_ptr) - NW'(r_rd_ptr))
                                             : (NW'(r_wr_ptr) + n_slots - NW'(r_rd_ptr));

    // Request decode: pointer update, store write and status.
    always_comb begin
        n_rd_ptr = r_rd_ptr;
        n_wr_ptr = r_wr_ptr;
        n_status = cqf_pkg::ST_OK;
        mem_we   = 1'b0;
        unique case (r_req)
            cqf_pkg::REQ_STATUS: begin
                n_status = cqf_pkg::ST_OK;
            end
            cqf_pkg::REQ_PUSH: begin
                if (wr_adv == r_rd_ptr) begin
                    n_status = cqf_pkg::ST_FULL;
                end else begin
                    mem_we   = 1'b1;
                    n_wr_ptr = wr_adv;
                end
            end
            cqf_pkg::REQ_POP: begin
                if (r_rd_ptr == r_wr_ptr) begin
                    n_status = cqf_pkg::ST_EMPTY;
                end else begin
                    n_rd_ptr = rd_adv;
                end
            end
            cqf_pkg::REQ_CLEAR: begin
                n_rd_ptr = '0;
                n_wr_ptr = '0;
            end
            default: begin
                n_status = cqf_pkg::ST_OK;
            end
        endcase
    end

    // Capture the accepted transaction.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req  <= i_req_type;
            r_data <= i_data_in;
        end
    end

    // Pointers; a configuration write empties the ring.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_wr) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
        end else if (i_cmd.exec) begin
            r_rd_ptr <= n_rd_ptr;
            r_wr_ptr <= n_wr_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status <= n_status;
        end
    end

    // Slot store: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && mem_we) begin
            r_mem[r_wr_ptr] <= DATA_WIDTH'(XW'(r_data));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_rd_head <= r_mem[r_rd_ptr];
            r_rd_tail <= r_mem[last_ptr];
            r_occ     <= occ;
            r_empty   <= (r_rd_ptr == r_wr_ptr);
            r_full    <= (wr_adv == r_rd_ptr);
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            o_status     <= r_status;
            o_head_value <= r_empty ? '1 : cqf_pkg::FIELD_W'(XW'(r_rd_head));
            o_tail_value <= r_empty ? '1 : cqf_pkg::FIELD_W'(XW'(r_rd_tail));
            o_occupancy  <= cqf_pkg::OCC_W'(r_occ);
            o_is_empty   <= r_empty;
            o_is_full    <= r_full;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

endmodule

/* sv/circular_queue_fifo.sv */
// One transaction at a time: a request is taken only in the idle state, and the
// controller then steps through update, slot read and result load, with the
// store read through registered ports; the load waits for a free output register.
// Reset: pointers go to zero (empty queue) and ring_slots to 10; the slot store
// keeps whatever it held and needs no clearing pass.
module circular_queue_fifo #(
    parameter int DEPTH      = cqf_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = cqf_pkg::DATA_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [cqf_pkg::ADDR_W-1:0]           paddr,
    input  logic [cqf_pkg::PDATA_W-1:0]          pwdata,
    output logic [cqf_pkg::PDATA_W-1:0]          prdata,
    output logic                                 pready,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [cqf_pkg::REQ_W-1:0]            i_req_type,
    input  logic signed [cqf_pkg::FIELD_W-1:0]   i_data_in,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [cqf_pkg::STATUS_W-1:0]         o_status,
    output logic signed [cqf_pkg::FIELD_W-1:0]   o_head_value,
    output logic signed [cqf_pkg::FIELD_W-1:0]   o_tail_value,
    output logic [cqf_pkg::OCC_W-1:0]            o_occupancy,
    output logic                                 o_is_empty,
    output logic                                 o_is_full
);

    logic [cqf_pkg::CFG_W-1:0]   ring_slots;
    logic                        cfg_wr;
    cqf_pkg::t_cmd               cmd;
    cqf_pkg::t_sts               sts;
    logic [cqf_pkg::FIELD_W-1:0] head_value;
    logic [cqf_pkg::FIELD_W-1:0] tail_value;

    // Configuration registers.
    cqf_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_ring_slots (ring_slots),
        .o_cfg_wr     (cfg_wr)
    );

    // Sequencer.
    cqf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // Pointers, slot store and output register.
    cqf_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_cfg_wr     (cfg_wr),
        .i_ring_slots (ring_slots),
        .i_req_type   (i_req_type),
        .i_data_in    (i_data_in),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_status     (o_status),
        .o_head_value (head_value),
        .o_tail_value (tail_value),
        .o_occupancy  (o_occupancy),
        .o_is_empty   (o_is_empty),
        .o_is_full    (o_is_full)
    );

    assign o_head_value = head_value;
    assign o_tail_value = tail_value;

endmodule

/* sv/cqf_checker.sv */
module cqf_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               o_in_ready,
    input  logic                               o_out_valid,
    input  logic                               i_out_ready,
    input  logic [cqf_pkg::STATUS_W-1:0]       o_status,
    input  logic signed [cqf_pkg::FIELD_W-1:0] o_head_value,
    input  logic signed [cqf_pkg::FIELD_W-1:0] o_tail_value,
    input  logic [cqf_pkg::OCC_W-1:0]          o_occupancy,
    input  logic                               o_is_empty,
    input  logic                               o_is_full
);

    // A waiting result holds until the transaction completes.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_status)
            && $stable(o_head_value) && $stable(o_occupancy)))
        else $error("result changed while stalled");

    // One transaction at a time: no accept right after an accept.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted while busy");

    // An empty queue shows no words and both values as all ones.
    a_empty_view: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_empty) |-> (o_occupancy == '0 && !o_is_full
            && o_head_value == -1 && o_tail_value == -1))
        else $error("empty flag disagrees with result");

    // A rejected push leaves a full queue; a rejected pop leaves an empty one.
    a_reject_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_status == cqf_pkg::ST_OK)
            || (o_status == cqf_pkg::ST_FULL && o_is_full)
            || (o_status == cqf_pkg::ST_EMPTY && o_is_empty)))
        else $error("status disagrees with flags");

endmodule

bind circular_queue_fifo cqf_checker u_cqf_checker (.*);
